>>> sv/cfde_pkg.sv
// Package: item types, command codes and default sizes for the character frame draw engine.
package cfde_pkg;

  localparam int unsigned DefColumns = 128;
  localparam int unsigned DefRows    = 32;

  localparam logic [7:0] BgCharReset = 8'd32;

  localparam logic [2:0] CMD_PLOT  = 3'd0;
  localparam logic [2:0] CMD_LINE  = 3'd1;
  localparam logic [2:0] CMD_RECT  = 3'd2;
  localparam logic [2:0] CMD_FILL  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  typedef struct packed {
    logic        [2:0]  command;
    logic signed [15:0] x_start;
    logic signed [15:0] y_start;
    logic signed [15:0] x_end;
    logic signed [15:0] y_end;
    logic        [7:0]  glyph;
  } draw_cmd_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic       off_screen;
  } draw_res_t;

endpackage

>>> sv/char_framebuffer_draw_engine_top.sv
// Top level: character frame store with plot, line, rectangle, fill, clear and read commands.
//
// Command items arrive on in_item_i with in_valid_i/in_stall_o; one result item
// per command leaves on out_item_o with out_valid_o/out_stall_i. An item moves at
// a rising edge where valid is high and stall is low.
// The engine works on one command at a time; in_stall_o is high while it is busy.
// Every cycle writes at most one cell through the single write port of the frame
// RAM; a line or rectangle outline is walked cell by cell, a fill covers the
// clipped strict interior of its rectangle and clear writes every cell.
// A finished result sits in the output register while the next command is taken;
// if the receiver stalls, a second result waits inside until that register frees.
// cfg_we_i/cfg_wdata_i write the background character (32 after reset), used by
// clear; write it only while idle. Reset empties the pipeline; frame contents are
// undefined until a clear or drawing command writes them.
module char_framebuffer_draw_engine_top
  import cfde_pkg::*;
#(
  parameter int unsigned COLUMNS = DefColumns,
  parameter int unsigned ROWS    = DefRows
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  draw_cmd_t in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output draw_res_t out_item_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = CELLS > 1 ? $clog2(CELLS) : 1;
  localparam int unsigned XW    = COLUMNS > 1 ? $clog2(COLUMNS) : 1;
  localparam int unsigned YW    = ROWS > 1 ? $clog2(ROWS) : 1;

  typedef enum logic [2:0] {
    StIdle, StPlot, StLine, StFillSetup, StFill, StClear, StRead, StFin
  } state_e;

  state_e             state_q;
  draw_cmd_t          cmd_q;
  logic        [7:0]  bg_q;
  logic signed [15:0] walk_x_q, walk_y_q;
  logic signed [15:0] tgt_x_q, tgt_y_q;
  logic        [1:0]  edge_q;
  logic signed [15:0] fx0_q, fx1_q, fy1_q;
  logic [AW-1:0]      clr_cnt_q;
  logic               res_off_q, res_ram_q;
  logic               out_valid_q;
  draw_res_t          out_q;

  logic               on_frame;
  logic [AW-1:0]      cell_addr;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr;
  logic [7:0]         ram_wdata, ram_rdata;
  logic               out_free;
  logic signed [16:0] fx0, fx1, fy0, fy1;
  logic signed [15:0] step_x, step_y;

  assign on_frame = !walk_x_q[15] && !walk_y_q[15]
                    && (walk_x_q < $signed(16'(COLUMNS)))
                    && (walk_y_q < $signed(16'(ROWS)));
  assign cell_addr = AW'(walk_y_q[YW-1:0]) * AW'(COLUMNS) + AW'(walk_x_q[XW-1:0]);

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    fx0 = {cmd_q.x_start[15], cmd_q.x_start} + 17'sd1;
    fx1 = {cmd_q.x_end[15], cmd_q.x_end} - 17'sd1;
    fy0 = {cmd_q.y_start[15], cmd_q.y_start} + 17'sd1;
    fy1 = {cmd_q.y_end[15], cmd_q.y_end} - 17'sd1;
    if (fx0 < 17'sd0) fx0 = 17'sd0;
    if (fy0 < 17'sd0) fy0 = 17'sd0;
    if (fx1 > $signed(17'(COLUMNS - 1))) fx1 = $signed(17'(COLUMNS - 1));
    if (fy1 > $signed(17'(ROWS - 1))) fy1 = $signed(17'(ROWS - 1));
  end

  always_comb begin
    step_x = walk_x_q;
    step_y = walk_y_q;
    if (walk_x_q < tgt_x_q) step_x = walk_x_q + 16'sd1;
    else if (walk_x_q > tgt_x_q) step_x = walk_x_q - 16'sd1;
    if (walk_y_q < tgt_y_q) step_y = walk_y_q + 16'sd1;
    else if (walk_y_q > tgt_y_q) step_y = walk_y_q - 16'sd1;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cell_addr;
    ram_wdata = cmd_q.glyph;
    unique case (state_q)
      StPlot, StLine: ram_we = on_frame;
      StFill: ram_we = 1'b1;
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = bg_q;
      end
      StRead: ram_re = on_frame;
      default: ;
    endcase
  end

  cfde_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cell_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cmd_q       <= '0;
      bg_q        <= BgCharReset;
      walk_x_q    <= '0;
      walk_y_q    <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      edge_q      <= '0;
      fx0_q       <= '0;
      fx1_q       <= '0;
      fy1_q       <= '0;
      clr_cnt_q   <= '0;
      res_off_q   <= 1'b0;
      res_ram_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        bg_q <= cfg_wdata_i;
      end
      if (out_free) begin
        out_valid_q <= (state_q == StFin);
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            cmd_q     <= in_item_i;
            walk_x_q  <= in_item_i.x_start;
            walk_y_q  <= in_item_i.y_start;
            tgt_x_q   <= in_item_i.x_end;
            tgt_y_q   <= (in_item_i.command == CMD_RECT) ? in_item_i.y_start
                                                         : in_item_i.y_end;
            edge_q    <= '0;
            clr_cnt_q <= '0;
            res_off_q <= 1'b0;
            res_ram_q <= 1'b0;
            case (in_item_i.command)
              CMD_PLOT:  state_q <= StPlot;
              CMD_LINE:  state_q <= StLine;
              CMD_RECT:  state_q <= StLine;
              CMD_FILL:  state_q <= StFillSetup;
              CMD_CLEAR: state_q <= StClear;
              CMD_READ:  state_q <= StRead;
              default:   state_q <= StFin;
            endcase
          end
        end
        StPlot: begin
          res_off_q <= !on_frame;
          state_q   <= StFin;
        end
        StRead: begin
          res_off_q <= !on_frame;
          res_ram_q <= on_frame;
          state_q   <= StFin;
        end
        StLine: begin
          if (walk_x_q == tgt_x_q && walk_y_q == tgt_y_q) begin
            if (cmd_q.command == CMD_RECT && edge_q != 2'd3) begin
              edge_q <= edge_q + 2'd1;
              case (edge_q)
                2'd0: begin
                  tgt_x_q <= cmd_q.x_end;
                  tgt_y_q <= cmd_q.y_end;
                end
                2'd1: begin
                  tgt_x_q <= cmd_q.x_start;
                  tgt_y_q <= cmd_q.y_end;
                end
                default: begin
                  tgt_x_q <= cmd_q.x_start;
                  tgt_y_q <= cmd_q.y_start;
                end
              endcase
            end else begin
              edge_q  <= '0;
              state_q <= StFin;
            end
          end else begin
            walk_x_q <= step_x;
            walk_y_q <= step_y;
          end
        end
        StFillSetup: begin
          fx0_q    <= fx0[15:0];
          fx1_q    <= fx1[15:0];
          fy1_q    <= fy1[15:0];
          walk_x_q <= fx0[15:0];
          walk_y_q <= fy0[15:0];
          if (fx0 <= fx1 && fy0 <= fy1) begin
            state_q <= StFill;
          end else begin
            state_q <= StFin;
          end
        end
        StFill: begin
          if (walk_x_q == fx1_q) begin
            walk_x_q <= fx0_q;
            if (walk_y_q == fy1_q) begin
              state_q <= StFin;
            end else begin
              walk_y_q <= walk_y_q + 16'sd1;
            end
          end else begin
            walk_x_q <= walk_x_q + 16'sd1;
          end
        end
        StClear: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == AW'(CELLS - 1)) begin
            state_q <= StFin;
          end
        end
        StFin: begin
          if (out_free) begin
            out_q.off_screen    <= res_off_q;
            out_q.read_char     <= res_ram_q ? ram_rdata : 8'd0;
            state_q             <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> sv/cfde_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module cfde_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the character frame draw engine: directed and random commands.
module tb_top;
  import cfde_pkg::*;

  localparam int COLS = DefColumns;
  localparam int NROWS = DefRows;
  localparam int CELL_COUNT = COLS * NROWS;
  localparam int QUIET_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 400;
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  draw_cmd_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  draw_res_t out_item_o;

  logic [7:0] frame_cells [CELL_COUNT];
  logic [7:0] bg_char = BgCharReset;
  draw_res_t pending_results[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_gen = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  char_framebuffer_draw_engine_top #(
    .COLUMNS(COLS),
    .ROWS(NROWS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i(in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o(out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit on_frame(int x, int y);
    return x >= 0 && x < COLS && y >= 0 && y < NROWS;
  endfunction

  function automatic void put_cell(int x, int y, logic [7:0] ch);
    if (on_frame(x, y)) frame_cells[y * COLS + x] = ch;
  endfunction

  function automatic void trace_line(int x0, int y0, int x1, int y1, logic [7:0] ch);
    int x;
    int y;
    x = x0;
    y = y0;
    while (x != x1 || y != y1) begin
      put_cell(x, y, ch);
      if (x < x1) x++; else if (x > x1) x--;
      if (y < y1) y++; else if (y > y1) y--;
    end
    put_cell(x1, y1, ch);
  endfunction

  function automatic draw_res_t apply_draw_cmd(draw_cmd_t c);
    draw_res_t r;
    int xs, ys, xe, ye, xa, xb, ya, yb;
    r = '0;
    xs = int'(c.x_start);
    ys = int'(c.y_start);
    xe = int'(c.x_end);
    ye = int'(c.y_end);
    case (c.command)
      CMD_PLOT: begin
        if (on_frame(xs, ys)) put_cell(xs, ys, c.glyph);
        else r.off_screen = 1'b1;
      end
      CMD_LINE: trace_line(xs, ys, xe, ye, c.glyph);
      CMD_RECT: begin
        trace_line(xs, ys, xe, ys, c.glyph);
        trace_line(xe, ys, xe, ye, c.glyph);
        trace_line(xe, ye, xs, ye, c.glyph);
        trace_line(xs, ye, xs, ys, c.glyph);
      end
      CMD_FILL: begin
        // strict interior, clipped to the frame
        ya = (ys + 1 < 0) ? 0 : ys + 1;
        yb = (ye - 1 > NROWS - 1) ? NROWS - 1 : ye - 1;
        xa = (xs + 1 < 0) ? 0 : xs + 1;
        xb = (xe - 1 > COLS - 1) ? COLS - 1 : xe - 1;
        for (int y = ya; y <= yb; y++)
          for (int x = xa; x <= xb; x++)
            put_cell(x, y, c.glyph);
      end
      CMD_CLEAR: foreach (frame_cells[i]) frame_cells[i] = bg_char;
      CMD_READ: begin
        if (on_frame(xs, ys)) r.read_char = frame_cells[ys * COLS + xs];
        else r.off_screen = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic draw_cmd_t build_cmd(logic [2:0] op, int xs, int ys, int xe, int ye,
                                          logic [7:0] ch);
    draw_cmd_t c;
    c.command = op;
    c.x_start = xs[15:0];
    c.y_start = ys[15:0];
    c.x_end = xe[15:0];
    c.y_end = ye[15:0];
    c.glyph = ch;
    return c;
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int pick_x();
    if ($urandom_range(99) < 12) return int'($urandom_range(65535)) - 32768;
    return int'($urandom_range(COLS + 7)) - 4;
  endfunction

  function automatic int pick_y();
    if ($urandom_range(99) < 12) return int'($urandom_range(65535)) - 32768;
    return int'($urandom_range(NROWS + 7)) - 4;
  endfunction

  function automatic draw_cmd_t random_cmd();
    int r, xs, ys;
    logic [7:0] ch;
    r = $urandom_range(99);
    xs = pick_x();
    ys = pick_y();
    ch = 8'($urandom_range(255));
    if (r < 2)
      return build_cmd(CMD_CLEAR, xs, ys, pick_x(), pick_y(), ch);
    if (r < 5)
      return build_cmd((r < 4) ? CMD_SPARE_A : CMD_SPARE_B, $urandom_range(65535),
                       $urandom_range(65535), $urandom_range(65535), $urandom_range(65535), ch);
    if (r < 30)
      return build_cmd(CMD_PLOT, xs, ys, pick_x(), pick_y(), ch);
    if (r < 55)
      return build_cmd(CMD_READ, xs, ys, pick_x(), pick_y(), ch);
    if (r < 75)
      return build_cmd(CMD_LINE, xs, ys, clamp16(xs + int'($urandom_range(40)) - 20),
                       clamp16(ys + int'($urandom_range(24)) - 12), ch);
    if (r < 87)
      return build_cmd(CMD_RECT, xs, ys, clamp16(xs + int'($urandom_range(30)) - 6),
                       clamp16(ys + int'($urandom_range(16)) - 4), ch);
    return build_cmd(CMD_FILL, xs, ys, clamp16(xs + int'($urandom_range(26)) - 2),
                     clamp16(ys + int'($urandom_range(14)) - 2), ch);
  endfunction

  task automatic send_cmd(input draw_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_item_i <= c;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_draw_cmd(c));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_bg(input logic [7:0] v);
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bg_char = v;
  endtask

  // result checker
  always @(posedge clk_i) begin
    draw_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: read_char %0d off_screen %0d",
               out_item_o.read_char, out_item_o.off_screen);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.read_char !== want.read_char) begin
          $error("read_char: expected %0d, got %0d", want.read_char, out_item_o.read_char);
          fail_count++;
        end
        if (out_item_o.off_screen !== want.off_screen) begin
          $error("off_screen: expected %0d, got %0d", want.off_screen, out_item_o.off_screen);
          fail_count++;
        end
      end
    end
  end

  // receiver stall, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("char_framebuffer_draw_engine_top test failed");
        $finish;
      end
    end
  end

  task automatic test_plot_and_read();
    send_cmd(build_cmd(CMD_CLEAR, 0, 0, 0, 0, 8'h00));
    send_cmd(build_cmd(CMD_PLOT, 0, 0, 0, 0, 8'h41));
    send_cmd(build_cmd(CMD_PLOT, COLS - 1, NROWS - 1, 0, 0, 8'hFF));
    send_cmd(build_cmd(CMD_PLOT, -32768, -32768, 32767, 32767, 8'h00));
    send_cmd(build_cmd(CMD_PLOT, 32767, 32767, -32768, -32768, 8'h11));
    send_cmd(build_cmd(CMD_READ, 0, 0, 0, 0, 8'h00));
    send_cmd(build_cmd(CMD_READ, COLS - 1, NROWS - 1, 0, 0, 8'h00));
    send_cmd(build_cmd(CMD_READ, -1, 0, 0, 0, 8'h00));
    send_cmd(build_cmd(CMD_READ, 5, NROWS, 0, 0, 8'h00));
  endtask

  task automatic test_lines();
    send_cmd(build_cmd(CMD_LINE, 2, 2, 12, 5, 8'h2A));
    // full-range diagonal crossing the whole frame
    send_cmd(build_cmd(CMD_LINE, -32768, -32768, 32767, 32767, 8'h23));
    send_cmd(build_cmd(CMD_LINE, 32767, -32768, 32760, -32765, 8'h40));
    send_cmd(build_cmd(CMD_READ, 20, 20, 0, 0, 8'h00));
  endtask

  task automatic test_rectangles();
    send_cmd(build_cmd(CMD_RECT, 10, 8, 20, 14, 8'h52));
    // corners given bottom-right first
    send_cmd(build_cmd(CMD_RECT, 40, 20, 30, 12, 8'h72));
    send_cmd(build_cmd(CMD_READ, 20, 11, 0, 0, 8'h00));
    send_cmd(build_cmd(CMD_READ, 30, 16, 0, 0, 8'h00));
  endtask

  task automatic test_fills();
    send_cmd(build_cmd(CMD_FILL, 50, 2, 60, 9, 8'h46));
    send_cmd(build_cmd(CMD_FILL, 70, 3, 71, 9, 8'h66));
    send_cmd(build_cmd(CMD_READ, 55, 5, 0, 0, 8'h00));
    send_cmd(build_cmd(CMD_FILL, -32768, -32768, 32767, 32767, 8'h00));
    send_cmd(build_cmd(CMD_READ, 64, 16, 0, 0, 8'h00));
  endtask

  task automatic test_unused_codes();
    send_cmd(build_cmd(CMD_SPARE_A, 1234, -77, 32767, -32768, 8'hFF));
    send_cmd(build_cmd(CMD_SPARE_B, -1, -1, -1, -1, 8'hFF));
  endtask

  task automatic test_background_char();
    logic [7:0] values [4];
    values = '{8'h00, 8'hFF, 8'h00, BgCharReset};
    values[2] = 8'($urandom_range(1, 254));
    foreach (values[i]) begin
      wait_drained();
      write_bg(values[i]);
      send_cmd(build_cmd(CMD_CLEAR, 0, 0, 0, 0, 8'h00));
      send_cmd(build_cmd(CMD_READ, $urandom_range(COLS - 1), $urandom_range(NROWS - 1),
                         0, 0, 8'h00));
      send_cmd(build_cmd(CMD_READ, COLS - 1, 0, 0, 0, 8'h00));
    end
    wait_drained();
  endtask

  task automatic test_random_phase(input int send_pct, input int stall_pct_v);
    send_idle_pct = send_pct;
    stall_pct = stall_pct_v;
    repeat (PHASE_ITEMS) send_cmd(random_cmd());
    wait_drained();
    write_bg(8'($urandom_range(255)));
  endtask

  task automatic test_backlog();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_gen++;
    for (int i = 0; i < 40; i++) begin
      if (i % 2 == 0) send_cmd(build_cmd(CMD_PLOT, i, 3, 0, 0, 8'(i + 1)));
      else send_cmd(build_cmd(CMD_READ, i - 1, 3, 0, 0, 8'h00));
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plot_and_read();
    test_lines();
    test_rectangles();
    test_fills();
    test_unused_codes();
    wait_drained();
    test_background_char();
    test_random_phase(0, 0);
    test_random_phase(77, 0);
    test_random_phase(0, 77);
    test_random_phase(14, 14);
    test_backlog();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("char_framebuffer_draw_engine_top test passed");
    end else begin
      $display("char_framebuffer_draw_engine_top test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/cfde_pkg.sv
sv/cfde_ram.sv
sv/char_framebuffer_draw_engine_top.sv
bench/tb_top.sv
